// File: sv/fcp_pkg.sv
`timescale 1ns / 1ps
package fcp_pkg;

  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd16;
  localparam int unsigned EV_W      = 2;
  localparam logic [EV_W-1:0] EVICT_MAX = 2'd2;
  localparam int unsigned FQ_DEPTH  = 2;
  localparam int unsigned FQ_PTR_W  = $clog2(FQ_DEPTH);
  localparam int unsigned FQ_CNT_W  = $clog2(FQ_DEPTH + 1);
  localparam int unsigned RQ_DEPTH  = 4;
  localparam int unsigned RQ_PTR_W  = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W  = $clog2(RQ_DEPTH + 1);
  // worst case results of one command: two evictions plus the final one
  localparam int unsigned RQ_NEED   = 3;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_UNLOCK = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    E_IDLE,
    E_MATCH,
    E_LOOKUP,
    E_ACT,
    E_EVSEL,
    E_EVREAD,
    E_FINISH
  } eng_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [31:0] data_handle;
    logic [15:0] data_length;
    logic        lock;
  } req_t;

  typedef struct packed {
    logic        evicted;
    logic [1:0]  status;
    logic [31:0] out_key;
    logic [31:0] out_handle;
    logic [15:0] out_length;
    logic        last;
  } rsp_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] key;
    logic [31:0] handle;
    logic [15:0] length;
    logic        lock;
  } work_t;

  typedef struct packed {
    logic        valid;
    work_t       work;
  } fe_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] handle;
    logic [15:0] length;
  } entry_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } sel_t;

  function automatic sel_t lowest_set(input logic [ENTRIES-1:0] vec);
    sel_t r;
    r = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: sv/fcp_front.sv
`timescale 1ns / 1ps
module fcp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  fcp_pkg::req_t  req_i,
  output fcp_pkg::fe_t   front_o,
  input  logic           pop_i
);

  fcp_pkg::work_t               slot_q [fcp_pkg::FQ_DEPTH];
  logic [fcp_pkg::FQ_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [fcp_pkg::FQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                         acc, take;
  fcp_pkg::work_t               cls;

  // decode the raw command into the engine's work item
  always_comb begin
    cls.cmd    = fcp_pkg::cmd_e'(req_i.command);
    cls.key    = req_i.key;
    cls.handle = req_i.data_handle;
    cls.length = req_i.data_length;
    cls.lock   = req_i.lock;
  end

  assign full          = (cnt_q == fcp_pkg::FQ_CNT_W'(fcp_pkg::FQ_DEPTH));
  assign acc           = push & ~full;
  assign front_o.valid = (cnt_q != '0);
  assign front_o.work  = slot_q[rd_q];
  assign take          = pop_i & front_o.valid;

  always_comb begin
    wr_d  = acc  ? fcp_pkg::FQ_PTR_W'(wr_q + 1'b1) : wr_q;
    rd_d  = take ? fcp_pkg::FQ_PTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + fcp_pkg::FQ_CNT_W'(acc) - fcp_pkg::FQ_CNT_W'(take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      slot_q[wr_q] <= cls;
    end
  end

endmodule

// File: sv/fcp_result_q.sv
`timescale 1ns / 1ps
module fcp_result_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fcp_pkg::rsp_t  rsp_i,
  output logic           room_o,
  output logic           empty,
  input  logic           pop,
  output fcp_pkg::rsp_t  rsp_o
);

  fcp_pkg::rsp_t                slot_q [fcp_pkg::RQ_DEPTH];
  logic [fcp_pkg::RQ_PTR_W-1:0] wr_q, rd_q;
  logic [fcp_pkg::RQ_CNT_W-1:0] cnt_q;
  logic                         take;

  assign empty  = (cnt_q == '0);
  assign take   = pop & ~empty;
  assign rsp_o  = slot_q[rd_q];
  // enough space for every result one command can make
  assign room_o = (cnt_q <= fcp_pkg::RQ_CNT_W'(fcp_pkg::RQ_DEPTH - fcp_pkg::RQ_NEED));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= fcp_pkg::RQ_PTR_W'(wr_q + 1'b1);
      if (take)   rd_q <= fcp_pkg::RQ_PTR_W'(rd_q + 1'b1);
      cnt_q <= cnt_q + fcp_pkg::RQ_CNT_W'(push_i) - fcp_pkg::RQ_CNT_W'(take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= rsp_i;
    end
  end

  overflow_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != fcp_pkg::RQ_CNT_W'(fcp_pkg::RQ_DEPTH)))
    else $error("result queue overflow");

endmodule

// File: sv/fcp_engine.sv
`timescale 1ns / 1ps
module fcp_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fcp_pkg::fe_t              front_i,
  output logic                      pop_o,
  input  logic                      room_i,
  input  logic [fcp_pkg::CAP_W-1:0] capacity_i,
  output logic                      push_o,
  output fcp_pkg::rsp_t             rsp_o
);

  localparam int unsigned N = fcp_pkg::ENTRIES;
  localparam int unsigned IW = fcp_pkg::IDX_W;
  localparam int unsigned CW = fcp_pkg::CNT_W;

  fcp_pkg::eng_state_e state_q, state_d;
  fcp_pkg::work_t      work_q;
  fcp_pkg::entry_t     fin_q, fin_d;
  fcp_pkg::entry_t     mem [N];
  fcp_pkg::entry_t     rdata_q;
  logic [N-1:0]        valid_q, locked_q, match_q, match_vec, cand, oldest_vec;
  logic [31:0]         key_q [N];
  logic [N-1:0]        older_q [N];
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                hit_q;
  logic [IW-1:0]       idx_q, victim_q, victim_d, rd_addr;
  logic [fcp_pkg::EV_W-1:0] ev_q, ev_d;
  fcp_pkg::sel_t       lk, ol, fr;
  logic                over;
  logic                drop_en, stamp_en, unlock_en, ins_en, dec, inc;
  logic [IW-1:0]       drop_idx, stamp_idx;

  // key match, all slots in parallel
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_vec[i] = valid_q[i] & (key_q[i] == work_q.key);
    end
  end

  // oldest unlocked entry: the one older than every other candidate
  always_comb begin
    logic [N-1:0] row;
    cand = valid_q & ~locked_q;
    for (int i = 0; i < N; i++) begin
      row           = older_q[i] | ~cand;
      row[i]        = 1'b1;
      oldest_vec[i] = cand[i] & (&row);
    end
  end

  assign lk   = fcp_pkg::lowest_set(match_q);
  assign ol   = fcp_pkg::lowest_set(oldest_vec);
  assign fr   = fcp_pkg::lowest_set(~valid_q);
  assign over = (fcp_pkg::CMP_W'(cnt_q) >= fcp_pkg::CMP_W'(capacity_i));

  always_comb begin
    state_d   = state_q;
    fin_d     = fin_q;
    victim_d  = victim_q;
    ev_d      = ev_q;
    pop_o     = 1'b0;
    push_o    = 1'b0;
    rsp_o     = '0;
    drop_en   = 1'b0;
    drop_idx  = idx_q;
    stamp_en  = 1'b0;
    stamp_idx = idx_q;
    unlock_en = 1'b0;
    ins_en    = 1'b0;
    rd_addr   = idx_q;
    case (state_q)
      fcp_pkg::E_IDLE: begin
        if (front_i.valid && room_i) begin
          pop_o   = 1'b1;
          state_d = fcp_pkg::E_MATCH;
        end
      end
      fcp_pkg::E_MATCH: begin
        state_d = fcp_pkg::E_LOOKUP;
      end
      fcp_pkg::E_LOOKUP: begin
        rd_addr = lk.idx;
        state_d = fcp_pkg::E_ACT;
      end
      fcp_pkg::E_ACT: begin
        rsp_o.last = 1'b1;
        if (work_q.cmd == fcp_pkg::CMD_SET) begin
          drop_en      = hit_q;
          fin_d.key    = work_q.key;
          fin_d.handle = work_q.handle;
          fin_d.length = work_q.length;
          ev_d         = '0;
          state_d      = fcp_pkg::E_EVSEL;
        end else if (!hit_q) begin
          push_o       = 1'b1;
          rsp_o.status = fcp_pkg::ST_MISS;
          state_d      = fcp_pkg::E_IDLE;
        end else begin
          fin_d = rdata_q;
          if (work_q.cmd == fcp_pkg::CMD_UNLOCK && locked_q[idx_q]) begin
            unlock_en = 1'b1;
            stamp_en  = 1'b1;
            ev_d      = '0;
            state_d   = fcp_pkg::E_EVSEL;
          end else begin
            drop_en          = (work_q.cmd == fcp_pkg::CMD_DELETE);
            push_o           = 1'b1;
            rsp_o.status     = fcp_pkg::ST_OK;
            rsp_o.out_key    = rdata_q.key;
            rsp_o.out_handle = rdata_q.handle;
            rsp_o.out_length = rdata_q.length;
            state_d          = fcp_pkg::E_IDLE;
          end
        end
      end
      fcp_pkg::E_EVSEL: begin
        if (ev_q < fcp_pkg::EVICT_MAX && over && ol.found) begin
          victim_d = ol.idx;
          rd_addr  = ol.idx;
          state_d  = fcp_pkg::E_EVREAD;
        end else begin
          state_d = fcp_pkg::E_FINISH;
        end
      end
      fcp_pkg::E_EVREAD: begin
        push_o           = 1'b1;
        rsp_o.evicted    = 1'b1;
        rsp_o.status     = fcp_pkg::ST_OK;
        rsp_o.out_key    = rdata_q.key;
        rsp_o.out_handle = rdata_q.handle;
        rsp_o.out_length = rdata_q.length;
        drop_en          = 1'b1;
        drop_idx         = victim_q;
        ev_d             = ev_q + 1'b1;
        state_d          = fcp_pkg::E_EVSEL;
      end
      fcp_pkg::E_FINISH: begin
        push_o           = 1'b1;
        rsp_o.last       = 1'b1;
        rsp_o.status     = fcp_pkg::ST_OK;
        rsp_o.out_key    = fin_q.key;
        rsp_o.out_handle = fin_q.handle;
        rsp_o.out_length = fin_q.length;
        if (work_q.cmd == fcp_pkg::CMD_SET) begin
          if (fr.found) begin
            ins_en    = 1'b1;
            stamp_en  = 1'b1;
            stamp_idx = fr.idx;
          end else begin
            rsp_o.status = fcp_pkg::ST_FULL;
          end
        end
        state_d = fcp_pkg::E_IDLE;
      end
      default: begin
        state_d = fcp_pkg::E_IDLE;
      end
    endcase
  end

  always_comb begin
    dec   = drop_en & ~locked_q[drop_idx] & (cnt_q != '0);
    inc   = unlock_en | (ins_en & ~work_q.lock);
    cnt_d = cnt_q - CW'(dec) + CW'(inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcp_pkg::E_IDLE;
      valid_q <= '0;
      cnt_q   <= '0;
      ev_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ev_q    <= ev_d;
      if (drop_en) valid_q[drop_idx]  <= 1'b0;
      if (ins_en)  valid_q[stamp_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) work_q <= front_i.work;
    if (state_q == fcp_pkg::E_MATCH) match_q <= match_vec;
    if (state_q == fcp_pkg::E_LOOKUP) begin
      hit_q <= lk.found;
      idx_q <= lk.idx;
    end
    fin_q    <= fin_d;
    victim_q <= victim_d;
    if (unlock_en) locked_q[idx_q] <= 1'b0;
    if (ins_en) begin
      locked_q[stamp_idx] <= work_q.lock;
      key_q[stamp_idx]    <= work_q.key;
    end
    // newest stamp: older than nobody, everyone else older than it
    if (stamp_en) begin
      for (int j = 0; j < N; j++) begin
        if (IW'(j) != stamp_idx) older_q[j][stamp_idx] <= 1'b1;
      end
      older_q[stamp_idx] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_en) mem[stamp_idx] <= fin_q;
    rdata_q <= mem[rd_addr];
  end

  cnt_tracks_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cand) == int'(cnt_q))
    else $error("unlocked count out of step with table");

  victim_is_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fcp_pkg::E_EVREAD) |-> cand[victim_q])
    else $error("victim is not an unlocked entry");

  evict_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_q <= fcp_pkg::EVICT_MAX)
    else $error("too many evictions");

  last_ends_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && rsp_o.last) |=> (state_q == fcp_pkg::E_IDLE))
    else $error("final result without return to idle");

endmodule

// File: sv/fifo_cache_with_pinned_entries.sv
`timescale 1ns / 1ps
// Sequence: get, delete, miss and unlock of an unlocked entry give their result from the
//   act state after match and lookup; set and unlock of a pinned entry go on through
//   eviction select, one eviction read per eviction (max 2), and finish.
// One command at a time in the engine's single sequencer; the next is taken back in idle.
// Reset (async, active low): table empty, unlocked count zero, capacity 16, queues empty;
//   no clearing pass, commands are taken right after reset.
module fifo_cache_with_pinned_entries (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command side
  input  logic                      push,
  output logic                      full,
  input  fcp_pkg::req_t             req_i,
  // result side
  output logic                      empty,
  input  logic                      pop,
  output fcp_pkg::rsp_t             rsp_o,
  // capacity register write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [fcp_pkg::CAP_W-1:0] cfg_data_i
);

  // Front: two-deep command queue that decodes each transaction.
  // Engine: key CAM, age matrix and payload memory, one command at a time.
  // Result queue: four deep, engine starts a command only with room for three results.

  logic [fcp_pkg::CAP_W-1:0] capacity_q;
  fcp_pkg::fe_t              front;
  logic                      eng_pop, room, eng_push;
  fcp_pkg::rsp_t             eng_rsp;

  // capacity writes are always taken; the user must send them only while no command is in flight (not enforced here)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= fcp_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  fcp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .req_i   (req_i),
    .front_o (front),
    .pop_i   (eng_pop)
  );

  fcp_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .front_i    (front),
    .pop_o      (eng_pop),
    .room_i     (room),
    .capacity_i (capacity_q),
    .push_o     (eng_push),
    .rsp_o      (eng_rsp)
  );

  fcp_result_q u_result_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (eng_push),
    .rsp_i  (eng_rsp),
    .room_o (room),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (rsp_o)
  );

endmodule
